FILE: hdl/ibin_pkg.sv
// ibin_pkg: field widths and shared types for the 2x2 binning block
// no dependencies; imported by the interfaces, ibin_scan and the core
`timescale 1ns / 1ps
`default_nettype none

package ibin_pkg;

    localparam int PIX_W  = 32;  // input pixel, two's complement
    localparam int PAIR_W = 33;  // sum of a horizontal pixel pair
    localparam int SUM_W  = 34;  // sum of a 2x2 block
    localparam int CFG_W  = 13;  // width of the image_side register write

    // scan position of the pixel at the head of the input channel
    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic last;     // bottom-right pixel of the image
    } pos_t;

endpackage

`default_nettype wire

FILE: hdl/ibin_if.sv
// ibin_if: valid/ready channel interfaces for pixels, binned sums and config
// depends on ibin_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface ibin_pixel_if;
    import ibin_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ibin_binned_if;
    import ibin_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] binned_sum;
    logic                    last_of_image;

    modport source (output valid, output binned_sum, output last_of_image, input ready);
    modport sink   (input valid, input binned_sum, input last_of_image, output ready);
endinterface

interface ibin_cfg_if;
    import ibin_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] image_side;

    modport source (output valid, output image_side, input ready);
    modport sink   (input valid, input image_side, output ready);
endinterface

`default_nettype wire

FILE: hdl/ibin_line_mem.sv
// ibin_line_mem: half-row line buffer of pair sums, one write and one read port
// registered read data; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module ibin_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 33
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ibin_scan.sv
// ibin_scan: side length register and raster column/row counters
// depends on ibin_pkg for pos_t and CFG_W
`timescale 1ns / 1ps
`default_nettype none

module ibin_scan #(
    parameter int MAX_SIDE = 4096,
    parameter int SIDE_W   = 13,
    parameter int COL_W    = 12,
    parameter int ADDR_W   = 11
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ibin_pkg::CFG_W-1:0]  cfg_side,
    input  wire logic                        step,
    output ibin_pkg::pos_t                   pos,
    output logic      [ADDR_W-1:0]           slot
);
    import ibin_pkg::*;

    localparam logic [31:0] MAX_L = 32'(MAX_SIDE);

    logic [SIDE_W-1:0] side_reg, side_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0] side_m1;
    logic              col_end;
    logic              row_end;
    logic [31:0]       even_val;
    logic [31:0]       sat_val;

    assign side_m1 = side_reg - SIDE_W'(1);
    assign col_end = (SIDE_W'(col_reg) == side_m1);
    assign row_end = (SIDE_W'(row_reg) == side_m1);

    assign pos.odd_col = col_reg[0];
    assign pos.odd_row = row_reg[0];
    assign pos.last    = col_end && row_end;
    assign slot        = ADDR_W'(col_reg >> 1);

    // round down to even, then clamp to 2..MAX_SIDE
    always_comb
    begin
        even_val = 32'(cfg_side & ~CFG_W'(1));
        priority if (even_val < 32'd2)
        begin
            sat_val = 32'd2;
        end
        else if (even_val > MAX_L)
        begin
            sat_val = MAX_L;
        end
        else
        begin
            sat_val = even_val;
        end
    end

    always_comb
    begin
        side_next = side_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        priority if (cfg_we)
        begin
            side_next = SIDE_W'(sat_val);
            col_next  = '0;
            row_next  = '0;
        end
        else if (step)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(2);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            side_reg <= side_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/image_bin_two_by_two_core.sv
// image_bin_two_by_two_core: streaming 2x2 binning of a square image
// depends on ibin_pkg, ibin_if, ibin_scan, ibin_line_mem
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | payload                         | item
// ----------+-----+---------------------------------+-------------------------------
// pixel     | in  | pixel_value[31:0] signed        | one pixel, raster order
// binned    | out | binned_sum[33:0] signed, last   | one 2x2 block sum, half-size raster
// side_cfg  | in  | image_side[12:0]                | new side length, restarts frame
//
// one pixel is taken per cycle while the output side keeps up; the line buffer
// sees one write (even rows) or one read (odd rows) per odd-column pixel.
// an odd-row, odd-column pixel launches its line buffer read at the accepting edge
// and enters the read stage; the output register loads it once free or being drained.
// pixel.ready drops only while the read stage holds an item and the output
// register is full and stalled. rst_n clears counters, side (to 2) and valids;
// the line buffer needs no clearing since every entry is written in an even row
// before the next odd row reads it.

module image_bin_two_by_two_core #(
    parameter int MAX_SIDE = 4096
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ibin_pixel_if.sink   pixel,
    ibin_binned_if.source binned,
    ibin_cfg_if.sink     side_cfg
);
    import ibin_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int COL_W  = $clog2(MAX_SIDE);
    localparam int DEPTH  = MAX_SIDE / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // handshakes
    logic              pix_accept;
    logic              cfg_we;
    logic              out_load;

    // scan position of the pixel on the input channel
    pos_t              pos;
    logic [ADDR_W-1:0] slot;

    // even-column pixel waiting for its right neighbor
    logic signed [PIX_W-1:0]  left_reg, left_next;
    logic signed [PAIR_W-1:0] pair_sum;

    // line buffer access
    logic                     mem_wr_en;
    logic                     mem_rd_en;
    logic        [PAIR_W-1:0] mem_rd_data;

    // read stage: item waiting for its line buffer entry
    logic                     s1_valid_reg, s1_valid_next;
    logic signed [PAIR_W-1:0] s1_pair_reg, s1_pair_next;
    logic                     s1_last_reg, s1_last_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic                     out_last_reg, out_last_next;

    // the user must send config writes only while idle; the block does not enforce it and always takes them
    assign side_cfg.ready = 1'b1;
    assign cfg_we         = side_cfg.valid;

    // read stage moves on when the output register is free or being drained
    assign out_load    = s1_valid_reg && (!out_valid_reg || binned.ready);
    assign pixel.ready = !s1_valid_reg || out_load;
    assign pix_accept  = pixel.valid && pixel.ready;

    ibin_scan #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W),
        .COL_W    (COL_W),
        .ADDR_W   (ADDR_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_side (side_cfg.image_side),
        .step     (pix_accept),
        .pos      (pos),
        .slot     (slot)
    );

    // horizontal pair sum, sign-extended by one bit
    assign pair_sum = {left_reg[PIX_W-1], left_reg} + {pixel.pixel_value[PIX_W-1],
                                                       pixel.pixel_value};

    // even rows store the pair, odd rows fetch the stored pair above
    assign mem_wr_en = pix_accept && pos.odd_col && !pos.odd_row;
    assign mem_rd_en = pix_accept && pos.odd_col && pos.odd_row;

    ibin_line_mem #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .DATA_W  (PAIR_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot),
        .wr_data (pair_sum),
        .rd_en   (mem_rd_en),
        .rd_addr (slot),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        left_next = left_reg;
        if (pix_accept && !pos.odd_col)
        begin
            left_next = pixel.pixel_value;
        end
    end

    // read stage; a new read only starts when the stage is empty or leaving,
    // so the buffer's read register holds while the stage is stalled
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !out_load;
        s1_pair_next  = s1_pair_reg;
        s1_last_next  = s1_last_reg;
        if (mem_rd_en)
        begin
            s1_valid_next = 1'b1;
            s1_pair_next  = pair_sum;
            s1_last_next  = pos.last;
        end
    end

    // output register: upper pair from the buffer plus the lower pair
    always_comb
    begin
        out_valid_next = out_valid_reg && !binned.ready;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = {mem_rd_data[PAIR_W-1], mem_rd_data}
                           + {s1_pair_reg[PAIR_W-1], s1_pair_reg};
            out_last_next  = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pair_reg  <= s1_pair_next;
        s1_last_reg  <= s1_last_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    assign binned.valid         = out_valid_reg;
    assign binned.binned_sum    = out_sum_reg;
    assign binned.last_of_image = out_last_reg;

endmodule

`default_nettype wire
